// ===== rtl/a85_pkg.sv =====
// Shared types and constants of the base-85 stream encoder.
`timescale 1ns / 1ps
`default_nettype none
package a85_pkg;

    localparam int unsigned NUM_DIGITS          = 5;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

    localparam logic [31:0] RECIP_85    = 32'd3233857729;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam logic [6:0]  RADIX       = 7'd85;

    localparam logic [6:0] CH_ZERO_GROUP = 7'h7A;
    localparam logic [6:0] CH_DIGIT_BASE = 7'h21;
    localparam logic [6:0] CH_TILDE      = 7'h7E;
    localparam logic [6:0] CH_GT         = 7'h3E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  ndig;
        logic        zero_group;
        logic        trailer;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/a85_front.sv =====
// Front end: packs bytes into groups and issues a job on a full group or end of data.
`timescale 1ns / 1ps
`default_nettype none
module a85_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire a85_pkg::in_item_t s_item,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output a85_pkg::job_t          job
);
    import a85_pkg::*;

    logic [23:0] group_bytes_reg, group_bytes_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic        accept;
    logic        complete;
    logic [23:0] gb1;
    logic [1:0]  cnt1;
    logic [31:0] full_val;
    logic [31:0] part_val;

    assign s_ready  = job_ready;
    assign accept   = s_valid && s_ready;
    assign complete = s_item.has_byte && (group_count_reg == 2'd3);
    assign full_val = {group_bytes_reg, s_item.data_byte};

    always_comb begin
        if (complete) begin
            gb1  = '0;
            cnt1 = '0;
        end else if (s_item.has_byte) begin
            gb1  = {group_bytes_reg[15:0], s_item.data_byte};
            cnt1 = group_count_reg + 2'd1;
        end else begin
            gb1  = group_bytes_reg;
            cnt1 = group_count_reg;
        end
    end

    always_comb begin
        case (cnt1)
            2'd1:    part_val = {gb1[7:0], 24'd0};
            2'd2:    part_val = {gb1[15:0], 16'd0};
            2'd3:    part_val = {gb1, 8'd0};
            default: part_val = '0;
        endcase
    end

    always_comb begin
        job.trailer    = s_item.end_of_data;
        job.zero_group = 1'b0;
        job.value      = '0;
        job.ndig       = '0;
        if (complete) begin
            job.value      = full_val;
            job.ndig       = 3'(NUM_DIGITS);
            job.zero_group = (full_val == '0);
        end else if (s_item.end_of_data && (cnt1 != 2'd0)) begin
            job.value = part_val;
            job.ndig  = {1'b0, cnt1} + 3'd1;
        end
    end

    assign job_valid = s_valid && (complete || s_item.end_of_data);

    always_comb begin
        group_bytes_next = group_bytes_reg;
        group_count_next = group_count_reg;
        if (accept) begin
            if (s_item.end_of_data) begin
                group_bytes_next = '0;
                group_count_next = '0;
            end else begin
                group_bytes_next = gb1;
                group_count_next = cnt1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_bytes_reg <= '0;
            group_count_reg <= '0;
        end else begin
            group_bytes_reg <= group_bytes_next;
            group_count_reg <= group_count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/a85_queue.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module a85_queue #(
    parameter int unsigned DEPTH = a85_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire a85_pkg::job_t  push_job,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output a85_pkg::job_t       pop_job
);
    import a85_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/a85_back.sv =====
// Back end: base-85 digit conversion stage followed by the character output stage.
`timescale 1ns / 1ps
`default_nettype none
module a85_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire a85_pkg::job_t  job,
    output logic                m_valid,
    input  wire logic           m_ready,
    output a85_pkg::out_item_t  m_item
);
    import a85_pkg::*;

    // conversion stage
    logic        cv_valid_reg, cv_valid_next;
    logic [2:0]  cv_step_reg, cv_step_next;
    logic [31:0] cv_cur_reg, cv_cur_next;
    logic [6:0]  cv_dig_reg [NUM_DIGITS];
    logic [2:0]  cv_ndig_reg;
    logic        cv_zch_reg;
    logic        cv_trl_reg;
    logic [63:0] prod;
    logic [25:0] quot;
    logic [6:0]  quot_x85;
    logic [6:0]  rem;
    logic [2:0]  dig_idx;
    logic        cv_busy;
    logic        cv_done;
    logic        load;
    logic        handoff;

    // output stage
    logic        em_valid_reg, em_valid_next;
    logic [2:0]  em_pos_reg, em_pos_next;
    logic [6:0]  em_dig_reg [NUM_DIGITS];
    logic [2:0]  em_ndig_reg;
    logic        em_zch_reg;
    logic        em_trl_reg;
    logic [2:0]  nbody;
    logic [2:0]  total;
    logic        em_last;
    logic        em_free;

    assign prod     = cv_cur_reg * RECIP_85;
    assign quot     = prod[63:RECIP_SHIFT];
    assign quot_x85 = quot[6:0] * RADIX;
    assign rem      = cv_cur_reg[6:0] - quot_x85;
    assign dig_idx  = 3'(NUM_DIGITS - 1) - cv_step_reg;

    assign cv_busy   = cv_valid_reg && (cv_step_reg != 3'(NUM_DIGITS));
    assign cv_done   = cv_valid_reg && (cv_step_reg == 3'(NUM_DIGITS));
    assign handoff   = cv_done && em_free;
    assign job_ready = !cv_valid_reg || handoff;
    assign load      = job_valid && job_ready;

    always_comb begin
        cv_valid_next = cv_valid_reg;
        cv_step_next  = cv_step_reg;
        cv_cur_next   = cv_cur_reg;
        if (handoff) begin
            cv_valid_next = 1'b0;
        end
        if (load) begin
            cv_valid_next = 1'b1;
            cv_cur_next   = job.value;
            cv_step_next  = (job.zero_group || (job.ndig == '0)) ? 3'(NUM_DIGITS) : '0;
        end else if (cv_busy) begin
            cv_cur_next  = {6'd0, quot};
            cv_step_next = cv_step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_valid_reg <= 1'b0;
            cv_step_reg  <= '0;
        end else begin
            cv_valid_reg <= cv_valid_next;
            cv_step_reg  <= cv_step_next;
        end
    end

    always_ff @(posedge aclk) begin
        cv_cur_reg <= cv_cur_next;
        if (load) begin
            cv_ndig_reg <= job.ndig;
            cv_zch_reg  <= job.zero_group;
            cv_trl_reg  <= job.trailer;
        end
        if (!load && cv_busy) begin
            cv_dig_reg[dig_idx] <= rem;
        end
    end

    assign nbody   = em_zch_reg ? 3'd1 : em_ndig_reg;
    assign total   = nbody + (em_trl_reg ? 3'd2 : 3'd0);
    assign em_last = (em_pos_reg == total - 3'd1);
    assign em_free = !em_valid_reg || (m_ready && em_last);
    assign m_valid = em_valid_reg;

    always_comb begin
        m_item.last_of_run = em_last;
        if (em_pos_reg < nbody) begin
            m_item.out_char = em_zch_reg ? CH_ZERO_GROUP
                                         : em_dig_reg[em_pos_reg] + CH_DIGIT_BASE;
        end else if (em_pos_reg == nbody) begin
            m_item.out_char = CH_TILDE;
        end else begin
            m_item.out_char = CH_GT;
        end
    end

    always_comb begin
        em_valid_next = em_valid_reg;
        em_pos_next   = em_pos_reg;
        if (em_valid_reg && m_ready) begin
            if (em_last) begin
                em_valid_next = 1'b0;
            end else begin
                em_pos_next = em_pos_reg + 3'd1;
            end
        end
        if (handoff) begin
            em_valid_next = 1'b1;
            em_pos_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
            em_pos_reg   <= '0;
        end else begin
            em_valid_reg <= em_valid_next;
            em_pos_reg   <= em_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (handoff) begin
            em_dig_reg  <= cv_dig_reg;
            em_ndig_reg <= cv_ndig_reg;
            em_zch_reg  <= cv_zch_reg;
            em_trl_reg  <= cv_trl_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ascii85_stream_encoder.sv =====
// Top level of the base-85 stream encoder: front end, job queue and back end.
//
//  channel   direction  payload     transaction when
//  s_        in         in_item_t   s_valid && s_ready
//  m_        out        out_item_t  m_valid && m_ready
//
// While a run is out and m_ready is high, one character leaves per cycle. A job
// with digits holds the divide-by-85 stage while it computes one digit per cycle,
// then until hand-off; a zero group or bare trailer waits there only for hand-off.
// Bytes that only fill a group and idle transactions issue no job and wait on s_ready.
// Reset is synchronous and clears the group and all stage valid flags.
// A stalled m_ side backs up the queue; s_ready falls only when it is full.
`timescale 1ns / 1ps
`default_nettype none
module ascii85_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = a85_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire a85_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output a85_pkg::out_item_t      m_item
);
    import a85_pkg::*;

    logic fq_valid, fq_ready;
    job_t fq_job;
    logic qb_valid, qb_ready;
    job_t qb_job;

    a85_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    a85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    a85_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
`default_nettype wire

// ===== rtl/a85_checker.sv =====
// Port-level checks of the base-85 stream encoder and their bind.
`timescale 1ns / 1ps
`default_nettype none
module a85_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire a85_pkg::out_item_t m_item
);
    import a85_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("output transaction changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.out_char >= CH_DIGIT_BASE && m_item.out_char <= 7'h75)
                     || m_item.out_char == CH_ZERO_GROUP
                     || m_item.out_char == CH_TILDE
                     || m_item.out_char == CH_GT))
        else $error("output character out of range");

    a_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.out_char == CH_TILDE
        |=> m_valid && m_item.out_char == CH_GT && m_item.last_of_run)
        else $error("tilde not followed by final '>'");

    a_tilde_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.out_char == CH_TILDE |-> !m_item.last_of_run)
        else $error("tilde flagged as last character");

endmodule

bind ascii85_stream_encoder a85_checker u_a85_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire
